// ===== rtl/q2e_pkg.sv =====
package q2e_pkg;

  // Width of the CORDIC vector datapath; covers any 24-bit operand pattern plus gain.
  localparam int DATA_W      = 52;
  // Angle accumulator, radians in Q4.20 with headroom for the pi pre-rotation.
  localparam int ACC_W       = 25;
  localparam int QIN_W       = 24;
  localparam int PROD_W      = 48;
  localparam int S_W         = 24;
  localparam int THR_W       = 23;
  localparam int RAD_W       = 45;
  localparam int ROOT_W      = 23;
  localparam int SQRT_STAGES = ROOT_W;
  // Side data travels from the operand stage to the CORDIC input.
  localparam int SIDE_DLY    = SQRT_STAGES + 2;
  localparam int AX_W        = 22;
  localparam int AYZ_W       = 23;

  localparam logic signed [S_W-1:0]   ONE_Q22     = S_W'(4194304);
  localparam logic signed [ACC_W-1:0] PI_Q20      = ACC_W'(3294199);
  localparam logic signed [ACC_W-1:0] HALF_PI_Q20 = ACC_W'(1647100);
  localparam logic [THR_W-1:0]        THR_RESET   = THR_W'(4194262);

  typedef struct packed {
    logic signed [S_W-1:0]    s;
    logic                     locked;
    logic signed [DATA_W-1:0] yy;
    logic signed [DATA_W-1:0] yx;
    logic signed [DATA_W-1:0] zy;
    logic signed [DATA_W-1:0] zx;
  } side_t;

  function automatic logic signed [ACC_W-1:0] atan_step(input int i);
    logic signed [ACC_W-1:0] r;
    r = '0;
    unique case (i)
      0: r = ACC_W'(823550);
      1: r = ACC_W'(486170);
      2: r = ACC_W'(256879);
      3: r = ACC_W'(130396);
      4: r = ACC_W'(65451);
      5: r = ACC_W'(32757);
      6: r = ACC_W'(16383);
      7: r = ACC_W'(8192);
      8: r = ACC_W'(4096);
      9: r = ACC_W'(2048);
      default: begin
        if (i <= 20) begin
          r = ACC_W'(1) <<< (20 - i);
        end else begin
          r = '0;
        end
      end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/quaternion_to_euler_angles.sv =====
// Quaternion to Euler angles, YXZ order, fully pipelined.
// An item is a quaternion (quat_x_i .. quat_w_i, signed Q1.22) and is taken at
// every rising edge where start is high and busy is low. busy is always low, so
// an item may be offered in every cycle and the block sustains one item per clock.
// Each item gives one result: angle_x_o (signed Q1.20 radians), angle_y_o and
// angle_z_o (signed Q2.20 radians) and gimbal_locked_o, shown for exactly one
// cycle with result_valid_o. On its way an item passes the product stage, the
// operand stage, the squaring stage, the radicand stage, a 23-stage bit-per-stage
// square root, and the three parallel CORDIC pipelines (one pre-rotation plus
// CORDIC_STAGES stages), then the output register. Results come out in input
// order and cannot be held off; the block has no buffering that needs a stall.
// The lock threshold is written through cfg_valid_i/cfg_data_i; cfg_ready_o is
// always high. Write it only while no item is in flight.
// Reset clears all valid bits, so no strobe appears until a new item enters,
// and loads the threshold with its default.
module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [q2e_pkg::QIN_W-1:0]      quat_x_i,
  input  logic signed [q2e_pkg::QIN_W-1:0]      quat_y_i,
  input  logic signed [q2e_pkg::QIN_W-1:0]      quat_z_i,
  input  logic signed [q2e_pkg::QIN_W-1:0]      quat_w_i,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [q2e_pkg::THR_W-1:0]             cfg_data_i,
  output logic                                  result_valid_o,
  output logic signed [q2e_pkg::AX_W-1:0]       angle_x_o,
  output logic signed [q2e_pkg::AYZ_W-1:0]      angle_y_o,
  output logic signed [q2e_pkg::AYZ_W-1:0]      angle_z_o,
  output logic                                  gimbal_locked_o
);

  localparam int PW  = q2e_pkg::PROD_W;
  localparam int W   = q2e_pkg::DATA_W;
  localparam int A   = q2e_pkg::ACC_W;
  localparam int SW  = q2e_pkg::S_W;
  localparam int DLY = q2e_pkg::SIDE_DLY;
  localparam int LKD = CORDIC_STAGES + 1;

  localparam logic signed [W-1:0] ONE44 = W'(1) <<< 44;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Configuration register.
  logic [q2e_pkg::THR_W-1:0] thr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= q2e_pkg::THR_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // Stage 1: all pairwise products.
  logic                 s1_vld_q;
  logic signed [PW-1:0] xw_q, yz_q, xz_q, yw_q, xy_q, zw_q, ww_q, zz_q, yy_q, xx_q;
  logic                 acc_in;

  assign acc_in = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= acc_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      xw_q <= quat_x_i * quat_w_i;
      yz_q <= quat_y_i * quat_z_i;
      xz_q <= quat_x_i * quat_z_i;
      yw_q <= quat_y_i * quat_w_i;
      xy_q <= quat_x_i * quat_y_i;
      zw_q <= quat_z_i * quat_w_i;
      ww_q <= quat_w_i * quat_w_i;
      zz_q <= quat_z_i * quat_z_i;
      yy_q <= quat_y_i * quat_y_i;
      xx_q <= quat_x_i * quat_x_i;
    end
  end

  // Stage 2: the saturated pitch sine, the lock decision and the atan2 operands.
  logic signed [W-1:0]  d_w, sh_w;
  logic signed [SW-1:0] s_d;
  logic [SW-1:0]        mag_w;
  logic                 lock_d;
  logic signed [W-1:0]  ny_y, ny_x, nz_y, nz_x, ly_y, ly_x;

  always_comb begin
    d_w  = W'(xw_q) - W'(yz_q);
    sh_w = d_w >>> 21;
    if (sh_w > W'(q2e_pkg::ONE_Q22)) begin
      s_d = q2e_pkg::ONE_Q22;
    end else if (sh_w < -W'(q2e_pkg::ONE_Q22)) begin
      s_d = -q2e_pkg::ONE_Q22;
    end else begin
      s_d = SW'(sh_w);
    end
    mag_w  = s_d[SW-1] ? SW'(-s_d) : SW'(s_d);
    lock_d = mag_w >= SW'(thr_q);
    ny_y   = (W'(xz_q) + W'(yw_q)) <<< 1;
    ny_x   = ((W'(ww_q) + W'(zz_q)) <<< 1) - ONE44;
    nz_y   = (W'(xy_q) + W'(zw_q)) <<< 1;
    nz_x   = ((W'(ww_q) + W'(yy_q)) <<< 1) - ONE44;
    ly_y   = (W'(yw_q) - W'(xz_q)) <<< 1;
    ly_x   = ((W'(ww_q) + W'(xx_q)) <<< 1) - ONE44;
  end

  logic           s2_vld_q;
  q2e_pkg::side_t s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  // A locked item sends a zero vector to the roll CORDIC, which gives zero.
  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      s2_q.s      <= s_d;
      s2_q.locked <= lock_d;
      s2_q.yy     <= lock_d ? ly_y : ny_y;
      s2_q.yx     <= lock_d ? ly_x : ny_x;
      s2_q.zy     <= lock_d ? '0 : nz_y;
      s2_q.zx     <= lock_d ? '0 : nz_x;
    end
  end

  // Stage 3: s squared. Stage 4: the radicand 1 - s^2 in Q1.44.
  logic                        s3_vld_q, s4_vld_q;
  logic signed [PW-1:0]        sq_q;
  logic [q2e_pkg::RAD_W-1:0]   rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      sq_q <= s2_q.s * s2_q.s;
    end
    if (s3_vld_q) begin
      rad_q <= q2e_pkg::RAD_W'(ONE44 - W'(sq_q));
    end
  end

  logic                         rt_vld;
  logic [q2e_pkg::ROOT_W-1:0]   root;

  q2e_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s4_vld_q),
    .rad_i  (rad_q),
    .vld_o  (rt_vld),
    .root_o (root)
  );

  // Side data waits for the square root alongside it.
  q2e_pkg::side_t side_q [DLY];
  always_ff @(posedge clk_i) begin
    side_q[0] <= s2_q;
    for (int k = 1; k < DLY; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  logic signed [W-1:0] ax_y, ax_x;
  assign ax_y = W'(side_q[DLY-1].s) <<< 22;
  assign ax_x = W'(root) <<< 22;

  logic                vx, vy_unused, vz_unused;
  logic signed [A-1:0] ang_x, ang_y, ang_z;

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_x (
    .clk_i (clk_i), .rst_ni (rst_ni), .vld_i (rt_vld),
    .y_i (ax_y), .x_i (ax_x), .vld_o (vx), .angle_o (ang_x)
  );

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_y (
    .clk_i (clk_i), .rst_ni (rst_ni), .vld_i (rt_vld),
    .y_i (side_q[DLY-1].yy), .x_i (side_q[DLY-1].yx), .vld_o (vy_unused), .angle_o (ang_y)
  );

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_z (
    .clk_i (clk_i), .rst_ni (rst_ni), .vld_i (rt_vld),
    .y_i (side_q[DLY-1].zy), .x_i (side_q[DLY-1].zx), .vld_o (vz_unused), .angle_o (ang_z)
  );

  // The lock flag follows the CORDIC latency.
  logic lk_q [LKD];
  always_ff @(posedge clk_i) begin
    lk_q[0] <= side_q[DLY-1].locked;
    for (int k = 1; k < LKD; k++) begin
      lk_q[k] <= lk_q[k-1];
    end
  end

  function automatic logic signed [A-1:0] clamp(input logic signed [A-1:0] v,
                                                input logic signed [A-1:0] lim);
    logic signed [A-1:0] r;
    r = v;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  logic                              out_vld_q;
  logic signed [A-1:0]               cx, cy, cz;

  assign cx = clamp(ang_x, q2e_pkg::HALF_PI_Q20);
  assign cy = clamp(ang_y, q2e_pkg::PI_Q20);
  assign cz = clamp(ang_z, q2e_pkg::PI_Q20);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vx && vy_unused && vz_unused;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vx) begin
      angle_x_o       <= cx[q2e_pkg::AX_W-1:0];
      angle_y_o       <= cy[q2e_pkg::AYZ_W-1:0];
      angle_z_o       <= cz[q2e_pkg::AYZ_W-1:0];
      gimbal_locked_o <= lk_q[LKD-1];
    end
  end

  assign result_valid_o = out_vld_q;

endmodule

// ===== rtl/q2e_isqrt.sv =====
module q2e_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          vld_i,
  input  logic [q2e_pkg::RAD_W-1:0]     rad_i,
  output logic                          vld_o,
  output logic [q2e_pkg::ROOT_W-1:0]    root_o
);

  localparam int N  = q2e_pkg::SQRT_STAGES;
  localparam int TW = q2e_pkg::RAD_W + 2;

  logic                        vld_q  [N];
  logic [q2e_pkg::RAD_W-1:0]   rem_q  [N];
  logic [q2e_pkg::ROOT_W-1:0]  root_q [N];

  // One result bit per stage, most significant first; rem holds v - root^2.
  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int B = N - 1 - k;
    logic                       vin;
    logic [q2e_pkg::RAD_W-1:0]  rin;
    logic [q2e_pkg::ROOT_W-1:0] oin;
    logic [TW-1:0]              trial;
    logic                       take;

    if (k == 0) begin : g_first
      assign vin = vld_i;
      assign rin = rad_i;
      assign oin = '0;
    end else begin : g_next
      assign vin = vld_q[k-1];
      assign rin = rem_q[k-1];
      assign oin = root_q[k-1];
    end

    assign trial = (TW'(oin) << (B + 1)) | (TW'(1) << (2 * B));
    assign take  = TW'(rin) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (vin) begin
        if (take) begin
          rem_q[k]  <= q2e_pkg::RAD_W'(TW'(rin) - trial);
          root_q[k] <= oin | (q2e_pkg::ROOT_W'(1) << B);
        end else begin
          rem_q[k]  <= rin;
          root_q[k] <= oin;
        end
      end
    end
  end

  assign vld_o  = vld_q[N-1];
  assign root_o = root_q[N-1];

endmodule

// ===== rtl/q2e_cordic.sv =====
module q2e_cordic #(
  parameter int STAGES = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                vld_i,
  input  logic signed [q2e_pkg::DATA_W-1:0]   y_i,
  input  logic signed [q2e_pkg::DATA_W-1:0]   x_i,
  output logic                                vld_o,
  output logic signed [q2e_pkg::ACC_W-1:0]    angle_o
);

  localparam int W = q2e_pkg::DATA_W;
  localparam int A = q2e_pkg::ACC_W;

  logic                pre_vld_q;
  logic                pre_zero_q;
  logic signed [W-1:0] pre_x_q, pre_y_q;
  logic signed [A-1:0] pre_acc_q;

  logic                vld_q  [STAGES];
  logic                zero_q [STAGES];
  logic signed [W-1:0] x_q    [STAGES];
  logic signed [W-1:0] y_q    [STAGES];
  logic signed [A-1:0] acc_q  [STAGES];

  // A vector in the left half plane is turned by pi first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= 1'b0;
    end else begin
      pre_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      pre_zero_q <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        pre_x_q   <= -x_i;
        pre_y_q   <= -y_i;
        pre_acc_q <= (y_i >= 0) ? q2e_pkg::PI_Q20 : -q2e_pkg::PI_Q20;
      end else begin
        pre_x_q   <= x_i;
        pre_y_q   <= y_i;
        pre_acc_q <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic                vin, zin;
    logic signed [W-1:0] xin, yin, xs, ys;
    logic signed [A-1:0] ain;

    if (i == 0) begin : g_first
      assign vin = pre_vld_q;
      assign zin = pre_zero_q;
      assign xin = pre_x_q;
      assign yin = pre_y_q;
      assign ain = pre_acc_q;
    end else begin : g_next
      assign vin = vld_q[i-1];
      assign zin = zero_q[i-1];
      assign xin = x_q[i-1];
      assign yin = y_q[i-1];
      assign ain = acc_q[i-1];
    end

    assign xs = xin >>> i;
    assign ys = yin >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (vin) begin
        zero_q[i] <= zin;
        if (yin >= 0) begin
          x_q[i]   <= xin + ys;
          y_q[i]   <= yin - xs;
          acc_q[i] <= ain + q2e_pkg::atan_step(i);
        end else begin
          x_q[i]   <= xin - ys;
          y_q[i]   <= yin + xs;
          acc_q[i] <= ain - q2e_pkg::atan_step(i);
        end
      end
    end
  end

  assign vld_o   = vld_q[STAGES-1];
  assign angle_o = zero_q[STAGES-1] ? '0 : acc_q[STAGES-1];

endmodule

// ===== tb/quaternion_to_euler_angles_test.sv =====
// Self-checking bench for the quaternion to YXZ Euler angle converter.
// Every accepted quaternion is run through a bit-exact predictor in this file
// and the expected angles are queued; each result strobe is compared field by
// field with the oldest entry. The lock threshold is changed between phases,
// only once the pipeline has drained.
module quaternion_to_euler_angles_test;

  localparam int STAGES = 24;
  // Covers the path from acceptance to the result strobe; allow some margin.
  localparam int DRAIN_CYCLES = STAGES + 40;
  // Cycles with neither an accepted item nor a result before giving up.
  localparam int STALL_LIMIT = 4000;
  localparam longint ONE = 64'sd4194304;
  localparam longint ONE44 = 64'sd1 << 44;
  localparam longint PI_R = 64'sd3294199;
  localparam longint HALF_PI_R = 64'sd1647100;

  typedef struct {
    logic signed [q2e_pkg::AX_W-1:0]  ax;
    logic signed [q2e_pkg::AYZ_W-1:0] ay;
    logic signed [q2e_pkg::AYZ_W-1:0] az;
    logic                             locked;
  } angles_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [q2e_pkg::QIN_W-1:0] quat_x_i = '0, quat_y_i = '0, quat_z_i = '0;
  logic signed [q2e_pkg::QIN_W-1:0] quat_w_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [q2e_pkg::THR_W-1:0] cfg_data_i = '0;
  logic result_valid_o;
  logic signed [q2e_pkg::AX_W-1:0] angle_x_o;
  logic signed [q2e_pkg::AYZ_W-1:0] angle_y_o, angle_z_o;
  logic gimbal_locked_o;

  angles_t pending_angles[$];
  longint threshold_model = 4194262;
  int error_count = 0;
  int quiet_cycles = 0;
  // When set, the sender offers items back to back with no gaps.
  bit no_gaps = 1'b0;

  always #5 clk_i = ~clk_i;

  quaternion_to_euler_angles #(.CORDIC_STAGES(STAGES)) i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .quat_x_i(quat_x_i), .quat_y_i(quat_y_i), .quat_z_i(quat_z_i), .quat_w_i(quat_w_i),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .result_valid_o(result_valid_o), .angle_x_o(angle_x_o), .angle_y_o(angle_y_o),
    .angle_z_o(angle_z_o), .gimbal_locked_o(gimbal_locked_o)
  );

  // Rotation angle of CORDIC stage i in Q3.20 radians.
  function automatic longint stage_angle(int i);
    longint lo[10] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048};
    if (i < 10) return lo[i];
    if (i <= 20) return 64'sd1 << (20 - i);
    return 0;
  endfunction

  // Vectoring CORDIC: drives the vector onto the positive x axis and
  // accumulates the angle. The left half plane is folded over first.
  function automatic longint vector_angle(longint yv, longint xv);
    longint acc, xs, ys;
    int sh;
    acc = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      acc = (yv >= 0) ? PI_R : -PI_R;
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < STAGES; i++) begin
      sh = (i > 62) ? 62 : i;
      xs = xv >>> sh;
      ys = yv >>> sh;
      if (yv >= 0) begin
        xv = xv + ys;
        yv = yv - xs;
        acc += stage_angle(i);
      end else begin
        xv = xv - ys;
        yv = yv + xs;
        acc -= stage_angle(i);
      end
    end
    return acc;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic angles_t predict_angles(longint x, longint y, longint z, longint w);
    angles_t res;
    longint s, mag, c, ay, az;
    bit lock;
    s = (x * w - y * z) >>> 21;
    s = clip(s, ONE);
    mag = (s < 0) ? -s : s;
    lock = mag >= threshold_model;
    c = int_sqrt(longint'(ONE44 - s * s));
    res.ax = q2e_pkg::AX_W'(clip(vector_angle(s * ONE, c * ONE), HALF_PI_R));
    if (!lock) begin
      ay = vector_angle(2 * (x * z + y * w), 2 * (w * w + z * z) - ONE44);
      az = vector_angle(2 * (x * y + z * w), 2 * (w * w + y * y) - ONE44);
    end else begin
      ay = vector_angle(2 * (y * w - x * z), 2 * (w * w + x * x) - ONE44);
      az = 0;
    end
    res.ay = q2e_pkg::AYZ_W'(clip(ay, PI_R));
    res.az = q2e_pkg::AYZ_W'(clip(az, PI_R));
    res.locked = lock;
    return res;
  endfunction

  // Offers one quaternion after a random gap and returns once it is taken.
  // start stays high between back-to-back items so it is never toggled in one step.
  task automatic send_quat(longint x, longint y, longint z, longint w);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    quat_x_i <= q2e_pkg::QIN_W'(x);
    quat_y_i <= q2e_pkg::QIN_W'(y);
    quat_z_i <= q2e_pkg::QIN_W'(z);
    quat_w_i <= q2e_pkg::QIN_W'(w);
    // busy is settled by the falling edge, so the next rising edge decides.
    forever begin
      @(negedge clk_i);
      if (!busy) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    pending_angles.push_back(predict_angles(x, y, z, w));
  endtask

  // Lets every queued result come out, then the pipeline empty, before returning.
  task automatic drain_pipeline();
    start <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(longint value);
    drain_pipeline();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= q2e_pkg::THR_W'(value);
    forever begin
      @(negedge clk_i);
      if (cfg_ready_o) break;
    end
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    threshold_model = value & ((64'd1 << q2e_pkg::THR_W) - 1);
  endtask

  // A random unit quaternion; occasionally a random point anywhere in range.
  task automatic send_random_quat();
    real q[4];
    real n;
    longint v[4];
    if ($urandom_range(0, 4) == 0) begin
      for (int k = 0; k < 4; k++) v[k] = longint'($urandom_range(0, 8388608)) - ONE;
    end else begin
      n = 0.0;
      for (int k = 0; k < 4; k++) begin
        q[k] = real'(int'($urandom_range(0, 2000000)) - 1000000);
        n += q[k] * q[k];
      end
      if (n == 0.0) begin
        q = '{0.0, 0.0, 0.0, 1.0};
        n = 1.0;
      end
      n = $sqrt(n);
      for (int k = 0; k < 4; k++) v[k] = clip(longint'($rtoi(q[k] / n * 4194304.0)), ONE);
    end
    send_quat(v[0], v[1], v[2], v[3]);
  endtask

  // Quaternion near a quarter turn about x, so that s lands close to one.
  task automatic send_near_lock_quat();
    longint d, e, f;
    d = longint'($urandom_range(0, 4000)) - 2000;
    e = longint'($urandom_range(0, 4000)) - 2000;
    f = longint'($urandom_range(0, 400)) - 200;
    if ($urandom_range(0, 1)) send_quat(2965821 + d, f, -f, 2965821 + e);
    else send_quat(-2965821 - d, f, f, 2965821 + e);
  endtask

  task automatic test_directed();
    send_quat(0, 0, 0, 0);
    send_quat(0, 0, 0, ONE);
    send_quat(0, 0, 0, -ONE);
    send_quat(ONE, 0, 0, 0);
    send_quat(-ONE, 0, 0, 0);
    send_quat(0, ONE, 0, 0);
    send_quat(0, -ONE, 0, 0);
    send_quat(0, 0, ONE, 0);
    send_quat(0, 0, -ONE, 0);
    // Exact gimbal lock in both directions, and s saturating well past one.
    send_quat(2965821, 0, 0, 2965821);
    send_quat(-2965821, 0, 0, 2965821);
    send_quat(ONE, ONE, -ONE, ONE);
    send_quat(-ONE, ONE, ONE, ONE);
    send_quat(ONE, ONE, ONE, ONE);
    send_quat(-ONE, -ONE, -ONE, -ONE);
    send_quat(2097152, 2097152, 2097152, 2097152);
    send_quat(1, -1, 1, -1);
    send_quat(ONE, -ONE, ONE, -ONE);
    send_quat(0, 2965821, 0, 2965821);
    send_quat(0, 0, 2965821, 2965821);
  endtask

  task automatic test_random(int count);
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 5) == 0) send_near_lock_quat();
      else send_random_quat();
    end
  endtask

  // Threshold settings including both extremes; a zero threshold locks everything.
  task automatic test_thresholds();
    write_threshold(0);
    test_random(60);
    write_threshold(ONE);
    test_directed();
    test_random(80);
    write_threshold(longint'($urandom_range(1, 4194303)));
    test_random(80);
    write_threshold(4194000 + longint'($urandom_range(0, 304)));
    test_random(100);
    write_threshold(4194262);
  endtask

  always @(posedge clk_i) begin
    angles_t exp_a;
    if (rst_ni && result_valid_o) begin
      if (pending_angles.size() == 0) begin
        $error("result with no quaternion outstanding");
        error_count++;
      end else begin
        exp_a = pending_angles.pop_front();
        if (angle_x_o !== exp_a.ax) begin
          $error("angle_x expected %0d got %0d", exp_a.ax, angle_x_o);
          error_count++;
        end
        if (angle_y_o !== exp_a.ay) begin
          $error("angle_y expected %0d got %0d", exp_a.ay, angle_y_o);
          error_count++;
        end
        if (angle_z_o !== exp_a.az) begin
          $error("angle_z expected %0d got %0d", exp_a.az, angle_z_o);
          error_count++;
        end
        if (gimbal_locked_o !== exp_a.locked) begin
          $error("gimbal_locked expected %0d got %0d", exp_a.locked, gimbal_locked_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which no item is taken and no result appears.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(240);
    test_thresholds();
    drain_pipeline();
    if (error_count == 0 && pending_angles.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
